// ===== src/wcal_pkg.sv =====
// Shared constants, types and opcodes of the waveform cell time calibration block.
`default_nettype none

package wcal_pkg;

  localparam int CELLS    = 1024;
  localparam int CHANNELS = 4;

  localparam int CELL_W  = $clog2(CELLS);
  localparam int CH_W    = 2;
  localparam int WIDTH_W = 24;
  localparam int VOLT_W  = 16;
  localparam int TIME_W  = 32;
  localparam int OP_W    = 2;

  // A tail sum of one channel holds up to CELLS widths.
  localparam int SUM_W = CELL_W + WIDTH_W + 1;
  // The running sum saturates at the largest positive time.
  localparam int RUN_W = TIME_W - 1;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  typedef logic [CELL_W-1:0]  cell_t;
  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [CH_W-1:0]    chan_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // Sample waiting for its width to come back from the table.
  typedef struct packed {
    logic                 valid;
    chan_t                channel;
    cell_t                pos;
    logic [VOLT_W-1:0]    raw;
  } sample_t;

endpackage

`default_nettype wire

// ===== src/waveform_cell_time_calibration.sv =====
// Top level of the cell time calibration block: width tables, offset engine and sample timing.
`default_nettype none

// Cell time calibration for a switched-capacitor sampler with CHANNELS channels
// of CELLS cells. The per-cell widths live in one synchronous RAM per channel.
// After reset the block zeroes those RAMs, with in_ready held low. A load
// transaction (opcode 0) writes one width. A sample transaction (opcode 2) is
// taken every cycle while results drain; its result passes through the
// registered read of the width RAM and then the output register, and the
// running time sum is updated in the cycle the result is formed so
// back-to-back samples chain without gaps.
// A start transaction (opcode 1) waits until no sample is in flight and then
// walks the width RAMs from the trigger cell to the last cell, one cell of all
// channels per cycle, then passes through ST_TAIL and ST_FIN (only ST_FIN when
// the trigger is cell 0). Offsets and the sum are saturated to the signed
// 32-bit time range, and time_saturated flags any clipping on the way to the
// reported time. Opcode 3 is accepted and ignored.
module waveform_cell_time_calibration (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [wcal_pkg::OP_W-1:0]    opcode,
  input  wire logic [wcal_pkg::CH_W-1:0]    channel,
  input  wire logic [wcal_pkg::CELL_W-1:0]  cell_req,
  input  wire logic [wcal_pkg::WIDTH_W-1:0] bin_width,
  input  wire logic [wcal_pkg::CELL_W-1:0]  trigger_cell,
  input  wire logic [wcal_pkg::VOLT_W-1:0]  raw_voltage,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [wcal_pkg::CH_W-1:0]    out_channel,
  output logic      [wcal_pkg::CELL_W-1:0]  out_cell,
  output logic signed [wcal_pkg::VOLT_W-1:0] voltage,
  output logic signed [wcal_pkg::TIME_W-1:0] sample_time,
  output logic                           time_saturated
);

  import wcal_pkg::*;

  // Controller states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam cell_t LAST_CELL = cell_t'(CELLS - 1);
  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  logic [2:0] state;
  logic [2:0] state_next;
  cell_t      addr;
  cell_t      addr_next;
  cell_t      trigger_position;
  logic       acc_vld;

  sum_t       tail [CHANNELS];
  logic signed [TIME_W-1:0] channel_offset [CHANNELS];
  logic       offset_clipped [CHANNELS];

  logic [RUN_W-1:0] running_time;
  logic             running_clipped;

  sample_t    p1;

  // Handshake decode.
  logic in_fire;
  logic out_free;
  logic advance;
  logic is_load;
  logic is_start;
  logic is_sample;

  assign out_free  = !out_valid || out_ready;
  assign advance   = p1.valid && out_free;
  assign in_ready  = (state == ST_RUN) && (!p1.valid || advance) &&
                     !((opcode == OP_START) && p1.valid);
  assign in_fire   = in_valid && in_ready;
  assign is_load   = in_fire && (opcode == OP_LOAD);
  assign is_start  = in_fire && (opcode == OP_START);
  assign is_sample = in_fire && (opcode == OP_SAMPLE);

  // Width RAMs, one per channel.
  cell_t  ram_waddr;
  width_t ram_wdata;
  logic   ram_re;
  cell_t  ram_raddr;
  width_t ram_rdata [CHANNELS];

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_waddr = addr;
      ram_wdata = '0;
    end else begin
      ram_waddr = cell_req;
      ram_wdata = bin_width;
    end
    if (state == ST_SUM) begin
      ram_re    = 1'b1;
      ram_raddr = addr;
    end else begin
      ram_re    = is_sample;
      // Wraps modulo CELLS by the width of the sum.
      ram_raddr = cell_t'(cell_req + trigger_position);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ram
    logic we;
    assign we = (state == ST_CLEAR) || (is_load && (channel == chan_t'(c)));
    wcal_ram #(
      .WIDTH(WIDTH_W),
      .DEPTH(CELLS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata[c])
    );
  end

  // Controller: clearing pass, then idle, then tail-sum walk on a start event.
  always_comb begin
    state_next = state;
    addr_next  = addr;
    case (state)
      ST_CLEAR: begin
        addr_next = addr + 1'b1;
        if (addr == LAST_CELL) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (is_start) begin
          addr_next  = trigger_cell;
          state_next = (trigger_cell == '0) ? ST_FIN : ST_SUM;
        end
      end
      ST_SUM: begin
        addr_next = addr + 1'b1;
        if (addr == LAST_CELL) begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: state_next = ST_FIN;
      ST_FIN:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      addr             <= '0;
      acc_vld          <= 1'b0;
      trigger_position <= '0;
    end else begin
      state   <= state_next;
      addr    <= addr_next;
      acc_vld <= (state == ST_SUM);
      if (is_start) begin
        trigger_position <= trigger_cell;
      end
    end
  end

  // Tail sums and channel offsets. Each offset is channel 0's tail minus this
  // channel's tail, clipped to the signed time range.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_off
    logic signed [SUM_W:0] diff;
    assign diff = $signed({1'b0, tail[0]}) - $signed({1'b0, tail[c]});

    always_ff @(posedge clk) begin
      if (is_start) begin
        tail[c] <= '0;
      end else if (acc_vld) begin
        tail[c] <= tail[c] + sum_t'(ram_rdata[c]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        channel_offset[c] <= '0;
        offset_clipped[c] <= 1'b0;
      end else if (state == ST_FIN) begin
        if (diff > $signed({{(SUM_W+1-TIME_W){1'b0}}, TIME_MAX})) begin
          channel_offset[c] <= TIME_MAX;
          offset_clipped[c] <= 1'b1;
        end else if (diff < $signed({{(SUM_W+1-TIME_W){1'b1}}, TIME_MIN})) begin
          channel_offset[c] <= TIME_MIN;
          offset_clipped[c] <= 1'b1;
        end else begin
          channel_offset[c] <= diff[TIME_W-1:0];
          offset_clipped[c] <= 1'b0;
        end
      end
    end
  end

  // Sample stage one: remember the sample while its width is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
    end else if (is_sample) begin
      p1.valid <= 1'b1;
    end else if (advance) begin
      p1.valid <= 1'b0;
    end
    if (is_sample) begin
      p1.channel <= channel;
      p1.pos     <= cell_req;
      p1.raw     <= raw_voltage;
    end
  end

  // Sample stage two: time from the running sum before this cell, then the
  // running sum advances by this cell's width. Position 0 restarts the sum.
  logic [RUN_W-1:0]         run_base;
  logic                     run_clip_base;
  logic signed [TIME_W:0]   time_full;
  logic [RUN_W:0]           run_sum;
  width_t                   cell_width;
  logic signed [TIME_W-1:0] offset_sel;
  logic                     time_clip;

  always_comb begin
    if (p1.pos == '0) begin
      run_base      = '0;
      run_clip_base = 1'b0;
    end else begin
      run_base      = running_time;
      run_clip_base = running_clipped;
    end
    cell_width = ram_rdata[p1.channel];
    offset_sel = channel_offset[p1.channel];
    time_full  = $signed({2'b00, run_base}) + $signed({offset_sel[TIME_W-1], offset_sel});
    run_sum    = {1'b0, run_base} + (RUN_W+1)'(cell_width);
    // The running sum is non-negative, so only the positive side can clip.
    time_clip  = (time_full[TIME_W] != time_full[TIME_W-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_time    <= '0;
      running_clipped <= 1'b0;
    end else if (state == ST_FIN) begin
      running_time    <= '0;
      running_clipped <= 1'b0;
    end else if (advance) begin
      if (run_sum[RUN_W]) begin
        running_time    <= RUN_MAX;
        running_clipped <= 1'b1;
      end else begin
        running_time    <= run_sum[RUN_W-1:0];
        running_clipped <= run_clip_base;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel    <= p1.channel;
      out_cell       <= p1.pos;
      voltage        <= $signed({~p1.raw[VOLT_W-1], p1.raw[VOLT_W-2:0]});
      sample_time    <= time_clip ? TIME_MAX : time_full[TIME_W-1:0];
      time_saturated <= time_clip || run_clip_base || offset_clipped[p1.channel];
    end
  end

endmodule

`default_nettype wire

// ===== src/wcal_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module wcal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/waveform_cell_time_calibration_tb.sv =====
// Self-checking testbench for the waveform cell time calibration block.
module waveform_cell_time_calibration_tb;
  import wcal_pkg::*;

  // Opcode 3 has no function. The block accepts it and drops it.
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

  localparam longint TIME_MAX = 64'sd2147483647;
  localparam longint TIME_MIN = -64'sd2147483648;

  // A start transaction walks the width RAMs, and the block clears its RAMs
  // after reset. Both fit easily in the cycle limit. The limit also covers the
  // longest receiver stalls.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = CELLS + 64;
  localparam int STIM_TXNS     = 820;
  localparam int REPORT_MAX    = 10;
  localparam int LONG_LOADS    = 140;
  localparam int LONG_SAMPLES  = 150;

  typedef struct {
    logic [OP_W-1:0]   op;
    chan_t             ch;
    cell_t             slot;
    width_t            width;
    cell_t             trig;
    logic [VOLT_W-1:0] raw;
    bit                hold_off;  // wait for every result before this one is sent
  } txn_t;

  typedef struct {
    chan_t                     ch;
    cell_t                     slot;
    logic signed [VOLT_W-1:0]  volt;
    logic signed [TIME_W-1:0]  stamp;
    logic                      sat;
  } timed_sample_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic [OP_W-1:0]           opcode       = OP_IDLE;
  logic [CH_W-1:0]           channel      = '0;
  logic [CELL_W-1:0]         cell_req     = '0;
  logic [WIDTH_W-1:0]        bin_width    = '0;
  logic [CELL_W-1:0]         trigger_cell = '0;
  logic [VOLT_W-1:0]         raw_voltage  = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic [CH_W-1:0]           out_channel;
  logic [CELL_W-1:0]         out_cell;
  logic signed [VOLT_W-1:0]  voltage;
  logic signed [TIME_W-1:0]  sample_time;
  logic                      time_saturated;

  waveform_cell_time_calibration i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .channel        (channel),
    .cell_req       (cell_req),
    .bin_width      (bin_width),
    .trigger_cell   (trigger_cell),
    .raw_voltage    (raw_voltage),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_cell       (out_cell),
    .voltage        (voltage),
    .sample_time    (sample_time),
    .time_saturated (time_saturated)
  );

  initial forever #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the width table, the event trigger, the
  // per-channel offsets with their clip marks, and the running time sum.
  // ---------------------------------------------------------------------------
  width_t                   cal_width [CHANNELS][CELLS];
  cell_t                    trig_pos;
  logic signed [TIME_W-1:0] chan_offset [CHANNELS];
  bit                       offset_clip [CHANNELS];
  logic [RUN_W-1:0]         run_time;
  bit                       run_clip;

  timed_sample_t expected_q[$];
  bit            results_pending = 1'b0;
  int            errors = 0;

  txn_t pending_q[$];
  int   txn_total = 0;
  bit   hold_next = 1'b0;

  // Sum of one channel's widths from the trigger cell to the last cell. The
  // sum is empty when the trigger is cell 0.
  function automatic longint tail_sum(input int ch, input cell_t from);
    longint acc = 0;
    if (from != '0)
      for (int k = int'(from); k < CELLS; k++) acc += cal_width[ch][k];
    return acc;
  endfunction

  // Applies one accepted transaction to the predictor. A sample transaction
  // queues the timed sample that the block must return for it.
  task automatic apply_calibration(input txn_t t);
    longint           ref_sum;
    longint           diff;
    longint           stamp;
    logic [RUN_W:0]   next_run;
    cell_t            idx;
    bit               sat;
    timed_sample_t    s;
    case (t.op)
      OP_LOAD: cal_width[t.ch][t.slot] = t.width;
      OP_START: begin
        trig_pos = t.trig;
        ref_sum  = tail_sum(0, t.trig);
        for (int c = 0; c < CHANNELS; c++) begin
          diff = ref_sum - tail_sum(c, t.trig);
          offset_clip[c] = (diff > TIME_MAX) || (diff < TIME_MIN);
          if (diff > TIME_MAX) diff = TIME_MAX;
          else if (diff < TIME_MIN) diff = TIME_MIN;
          chan_offset[c] = diff[TIME_W-1:0];
        end
        run_time = '0;
        run_clip = 1'b0;
      end
      OP_SAMPLE: begin
        // Position 0 restarts the running sum; any other position just adds on.
        if (t.slot == '0) begin
          run_time = '0;
          run_clip = 1'b0;
        end
        // The 10-bit add wraps the table index around the ring of cells.
        idx   = t.slot + trig_pos;
        sat   = offset_clip[t.ch] || run_clip;
        stamp = longint'(run_time) + longint'(chan_offset[t.ch]);
        if (stamp > TIME_MAX) begin
          stamp = TIME_MAX;
          sat   = 1'b1;
        end else if (stamp < TIME_MIN) begin
          stamp = TIME_MIN;
          sat   = 1'b1;
        end
        // The running sum takes this cell's width only after the time is formed.
        next_run = {1'b0, run_time} + cal_width[t.ch][idx];
        if (next_run > TIME_MAX) begin
          run_time = '1;
          run_clip = 1'b1;
        end else begin
          run_time = next_run[RUN_W-1:0];
        end
        s = '{t.ch, t.slot, t.raw ^ 16'h8000, stamp[TIME_W-1:0], sat};
        expected_q.push_back(s);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: sends the pending transactions in bursts with random gaps. An item
  // marked for hold-off is held back, with valid low, until every result
  // outstanding has been returned.
  // ---------------------------------------------------------------------------
  txn_t on_bus;
  int   gap_left   = 0;
  int   burst_left = 0;

  always @(posedge clk) begin : driver
    bit present;
    present = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_q.size() != 0 && pending_q[0].hold_off && (in_valid || results_pending)) begin
        present = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        on_bus  = pending_q.pop_front();
        present = 1'b1;
        opcode       <= on_bus.op;
        channel      <= on_bus.ch;
        cell_req     <= on_bus.slot;
        bin_width    <= on_bus.width;
        trigger_cell <= on_bus.trig;
        raw_voltage  <= on_bus.raw;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Mostly short bursts; now and then a long stretch with no gaps.
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= present;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a pattern, redrawn at random whenever the last
  // one runs out, from always ready to mostly stalled.
  // ---------------------------------------------------------------------------
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left  = 0;

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
        default:    out_ready <= (mode_left % 4 != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: feeds every accepted input transaction to the predictor, then
  // checks each accepted result against the oldest expected sample. The
  // prediction is made first so the check does not depend on the latency.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    txn_t          seen;
    timed_sample_t want;
    if (rst) begin
      foreach (cal_width[c, k]) cal_width[c][k] = '0;
      foreach (chan_offset[c]) begin
        chan_offset[c] = '0;
        offset_clip[c] = 1'b0;
      end
      trig_pos = '0;
      run_time = '0;
      run_clip = 1'b0;
      expected_q.delete();
      results_pending <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen = '{opcode, channel, cell_req, bin_width, trigger_cell, raw_voltage, 1'b0};
        apply_calibration(seen);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("unexpected result: ch %0d pos %0d v %0d t %0d sat %0b",
                     out_channel, out_cell, voltage, sample_time, time_saturated);
        end else begin
          want = expected_q.pop_front();
          if (out_channel !== want.ch || out_cell !== want.slot || voltage !== want.volt ||
              sample_time !== want.stamp || time_saturated !== want.sat) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display({"sample mismatch: expected ch %0d pos %0d v %0d t %0d sat %0b,",
                        " got ch %0d pos %0d v %0d t %0d sat %0b"},
                       want.ch, want.slot, want.volt, want.stamp, want.sat,
                       out_channel, out_cell, voltage, sample_time, time_saturated);
          end
        end
      end
      results_pending <= (expected_q.size() != 0);
    end
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("waveform_cell_time_calibration_tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders. Fields that an opcode does not use carry random values,
  // so the block is also checked for ignoring them.
  // ---------------------------------------------------------------------------
  task automatic push_txn(input logic [OP_W-1:0] op, input chan_t ch, input cell_t slot,
                          input width_t width, input cell_t trig, input logic [VOLT_W-1:0] raw);
    txn_t t;
    t = '{op, ch, slot, width, trig, raw, hold_next};
    hold_next = 1'b0;
    pending_q.push_back(t);
    if (op != OP_IDLE) txn_total++;
  endtask

  task automatic queue_load(input chan_t ch, input cell_t slot, input width_t width);
    push_txn(OP_LOAD, ch, slot, width, cell_t'($urandom), VOLT_W'($urandom));
  endtask

  task automatic queue_start(input cell_t trig);
    push_txn(OP_START, chan_t'($urandom), cell_t'($urandom), width_t'($urandom), trig,
             VOLT_W'($urandom));
  endtask

  task automatic queue_sample(input chan_t ch, input cell_t slot, input logic [VOLT_W-1:0] raw);
    push_txn(OP_SAMPLE, ch, slot, width_t'($urandom), cell_t'($urandom), raw);
  endtask

  task automatic queue_noise();
    push_txn(OP_IDLE, chan_t'($urandom), cell_t'($urandom), width_t'($urandom),
             cell_t'($urandom), VOLT_W'($urandom));
  endtask

  function automatic width_t pick_width();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return width_t'($urandom_range(0, 16'hFFFF));
      default: return width_t'($urandom);
    endcase
  endfunction

  // Loads a long stretch of near-maximum widths into one channel, starts an
  // event at its first cell and reads that channel across it. The running sum
  // passes the largest time after about 128 cells, and the offsets set against
  // it clip: those of the other channels when it is channel 0, else its own. A
  // few samples on a neighbor channel then show that channel's offset.
  task automatic queue_long_run(input chan_t ch, input cell_t base);
    hold_next = 1'b1;
    for (int k = 0; k < LONG_LOADS; k++)
      queue_load(ch, cell_t'(base + k), width_t'($urandom_range(24'hFF0000, 24'hFFFFFF)));
    queue_start(base);
    for (int k = 0; k < LONG_SAMPLES; k++) queue_sample(ch, cell_t'(k), VOLT_W'($urandom));
    for (int k = 0; k < 4; k++) queue_sample(chan_t'(ch + 1), cell_t'(k), VOLT_W'($urandom));
  endtask

  initial begin : stimulus
    int    episode;
    cell_t trig;
    chan_t ch;
    cell_t pos;

    // Directed part: extreme and alternating bit patterns, every opcode, a
    // trigger at both ends of the ring, and a sample out of order.
    queue_load(2'd0, 10'd0, 24'hFFFFFF);
    queue_load(2'd3, 10'h3FF, 24'hFFFFFF);
    queue_load(2'd1, 10'h155, 24'h555555);
    queue_load(2'd2, 10'h2AA, 24'hAAAAAA);
    queue_noise();
    queue_start(10'd0);
    queue_sample(2'd0, 10'd0, 16'h0000);
    queue_sample(2'd0, 10'd1, 16'hFFFF);
    queue_sample(2'd3, 10'h3FF, 16'h8000);
    queue_start(10'h3FF);
    queue_sample(2'd3, 10'd0, 16'h7FFF);
    queue_sample(2'd3, 10'd1, 16'h5555);
    queue_start(10'h155);
    queue_sample(2'd1, 10'd0, 16'hAAAA);
    queue_sample(2'd2, 10'h155, 16'h0001);
    queue_start(10'h2AA);
    queue_sample(2'd2, 10'd0, 16'hFFFE);
    queue_noise();
    queue_sample(2'd2, 10'h3FF, 16'h8001);

    // Random part: each episode loads some widths, usually starts an event and
    // then reads one channel in order from position 0, with the odd jump,
    // mid-run load or dropped opcode mixed in. Two episodes fill long runs of
    // large widths to drive the saturation paths.
    hold_next = 1'b1;
    episode   = 0;
    while (txn_total < STIM_TXNS) begin
      episode++;
      if (episode == 2) begin
        queue_long_run(2'd0, cell_t'($urandom_range(1, 200)));
      end else if (episode == 6) begin
        queue_long_run(chan_t'($urandom_range(1, 3)), cell_t'($urandom_range(400, 883)));
      end else begin
        if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
        repeat ($urandom_range(0, 20))
          queue_load(chan_t'($urandom), cell_t'($urandom), pick_width());
        if ($urandom_range(0, 5) != 0) begin
          case ($urandom_range(0, 7))
            0:       trig = '0;
            1:       trig = '1;
            default: trig = cell_t'($urandom);
          endcase
          queue_start(trig);
        end
        ch  = chan_t'($urandom);
        pos = '0;
        repeat ($urandom_range(1, 40)) begin
          case ($urandom_range(0, 19))
            0:       queue_noise();
            1:       queue_load(chan_t'($urandom), cell_t'($urandom), pick_width());
            2:       pos = cell_t'($urandom);
            default: ;
          endcase
          queue_sample(ch, pos, VOLT_W'($urandom));
          pos++;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Sampled at the falling edge, clear of the updates made at the rising one.
    while (pending_q.size() != 0 || in_valid) @(negedge clk);
    while (results_pending) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("waveform_cell_time_calibration_tb: done, clean");
    end else begin
      $display("waveform_cell_time_calibration_tb: done, errors");
    end
    $finish;
  end

endmodule
